// ===== rtl/vmog_pkg.sv =====
// Shared constants and types for the video marker overlay generator.
`timescale 1ns / 1ps

package vmog_pkg;

  // Widths fixed by the register map and the word fields
  localparam int unsigned DIM_WIDTH   = 12;
  localparam int unsigned HALF_WIDTH  = 8;
  localparam int unsigned IDX_WIDTH   = 5;
  localparam int unsigned FIELD_WIDTH = 11;
  localparam int unsigned PIXEL_WIDTH = 32;
  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned CFG_DATA_WIDTH = 12;

  localparam logic [PIXEL_WIDTH-1:0] OVERLAY_COLOUR = 32'h7f0000ff;
  localparam logic [DIM_WIDTH-1:0]   DIM_MAX        = 12'd2048;

  // Register reset values
  localparam logic [DIM_WIDTH-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_WIDTH-1:0]  FRAME_HEIGHT_RST = 12'd480;
  localparam logic [HALF_WIDTH-1:0] HALF_SIZE_RST    = 8'd2;

  // Parameter defaults
  localparam int unsigned MARKER_COUNT_DEF     = 20;
  localparam int unsigned COORD_BITS_DEF       = 11;
  localparam int unsigned BORDER_THICKNESS_DEF = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HALF_SIZE    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

endpackage

// ===== rtl/vmog_marker_match.sv =====
// Marker centre table and parallel square-window hit test.
`timescale 1ns / 1ps

module vmog_marker_match #(
  parameter int unsigned MARKER_COUNT = vmog_pkg::MARKER_COUNT_DEF,
  parameter int unsigned COORD_BITS   = vmog_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_en_i,
  input  logic [vmog_pkg::IDX_WIDTH-1:0]      load_index_i,
  input  logic [COORD_BITS-1:0]               load_x_i,
  input  logic [COORD_BITS-1:0]               load_y_i,
  input  logic [vmog_pkg::HALF_WIDTH-1:0]     half_size_i,
  input  logic [COORD_BITS-1:0]               pix_x_i,
  input  logic [COORD_BITS-1:0]               pix_y_i,
  output logic                                hit_o
);
  import vmog_pkg::*;

  localparam int unsigned EW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] mark_x_q [MARKER_COUNT];
  logic [COORD_BITS-1:0] mark_y_q [MARKER_COUNT];
  logic [MARKER_COUNT-1:0] hit_vec;

  // Each entry has its own write decode; out-of-range indexes hit nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MARKER_COUNT; k++) begin
        mark_x_q[k] <= '0;
        mark_y_q[k] <= '0;
      end
    end else if (load_en_i) begin
      for (int k = 0; k < MARKER_COUNT; k++) begin
        if (32'(load_index_i) == k) begin
          mark_x_q[k] <= load_x_i;
          mark_y_q[k] <= load_y_i;
        end
      end
    end
  end

  // Inclusive window mx-s..mx+s, written without subtraction to avoid wrap
  always_comb begin
    for (int k = 0; k < MARKER_COUNT; k++) begin
      hit_vec[k] = (EW'(pix_x_i) + EW'(half_size_i) >= EW'(mark_x_q[k]))
                && (EW'(pix_x_i) <= EW'(mark_x_q[k]) + EW'(half_size_i))
                && (EW'(pix_y_i) + EW'(half_size_i) >= EW'(mark_y_q[k]))
                && (EW'(pix_y_i) <= EW'(mark_y_q[k]) + EW'(half_size_i));
    end
  end

  assign hit_o = |hit_vec;

endmodule

// ===== rtl/video_marker_overlay_generator_top.sv =====
// Top level of the video marker overlay generator.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  -------------------------------------------
// in        in         in_valid_i / in_stall_o action, marker_index, marker_x, marker_y
// out       out        out_valid_o/out_stall_i pixel, start_of_frame, end_of_line
// cfg       in         cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One word per clock is sustained while the output does not stall: an accepted
// word is held in the input register, then a pixel request lands in the output
// register; a load retires from the input register without a result.
// Reset clears the counters, the marker table and all valids; config registers take reset values.
// A stall on the output holds the output register and, through it, the input
// register; the input side keeps taking words while the output has room.

module video_marker_overlay_generator_top #(
  parameter int unsigned MARKER_COUNT     = vmog_pkg::MARKER_COUNT_DEF,
  parameter int unsigned COORD_BITS       = vmog_pkg::COORD_BITS_DEF,
  parameter int unsigned BORDER_THICKNESS = vmog_pkg::BORDER_THICKNESS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [vmog_pkg::CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [vmog_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [vmog_pkg::IDX_WIDTH-1:0]       marker_index_i,
  input  logic [vmog_pkg::FIELD_WIDTH-1:0]     marker_x_i,
  input  logic [vmog_pkg::FIELD_WIDTH-1:0]     marker_y_i,
  // output words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [vmog_pkg::PIXEL_WIDTH-1:0]     pixel_o,
  output logic                                 start_of_frame_o,
  output logic                                 end_of_line_o
);
  import vmog_pkg::*;

  // Wide enough for the 12-bit dimensions, the counters and the border offset
  localparam int unsigned XW = ((COORD_BITS > DIM_WIDTH) ? COORD_BITS : DIM_WIDTH) + 2;

  // configuration registers
  logic [DIM_WIDTH-1:0]  frame_width_q, frame_height_q;
  logic [HALF_WIDTH-1:0] half_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      half_size_q    <= HALF_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        REG_HALF_SIZE:    half_size_q    <= cfg_wdata_i[HALF_WIDTH-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // input register
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_action_q;
  logic [IDX_WIDTH-1:0]     s1_index_q;
  logic [COORD_BITS-1:0]    s1_x_q, s1_y_q;

  logic out_valid_q, out_valid_d;
  logic out_free;
  logic s1_pixel;
  logic s1_adv;
  logic in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_pixel   = (s1_action_q == ACT_PIXEL);
  // A load retires at once; a pixel waits for room in the output register.
  assign s1_adv     = s1_valid_q && (!s1_pixel || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_index_q  <= marker_index_i;
      s1_x_q      <= COORD_BITS'(marker_x_i);
      s1_y_q      <= COORD_BITS'(marker_y_i);
    end
  end

  // raster counters
  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic                  pix_fire;

  assign pix_fire = s1_adv && s1_pixel;

  // Zero or oversized dimensions act as the maximum.
  logic [DIM_WIDTH-1:0] eff_w, eff_h;
  assign eff_w = (frame_width_q == '0 || frame_width_q > DIM_MAX) ? DIM_MAX : frame_width_q;
  assign eff_h = (frame_height_q == '0 || frame_height_q > DIM_MAX) ? DIM_MAX : frame_height_q;

  logic last_col, last_row;
  assign last_col = (XW'(col_q) >= XW'(eff_w) - XW'(1)) || (&col_q);
  assign last_row = (XW'(row_q) >= XW'(eff_h) - XW'(1)) || (&row_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pix_fire) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + COORD_BITS'(1);
      end else begin
        col_d = col_q + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // marker table and window test
  logic marker_hit;

  vmog_marker_match #(
    .MARKER_COUNT (MARKER_COUNT),
    .COORD_BITS   (COORD_BITS)
  ) u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (s1_adv && !s1_pixel),
    .load_index_i (s1_index_q),
    .load_x_i     (s1_x_q),
    .load_y_i     (s1_y_q),
    .half_size_i  (half_size_q),
    .pix_x_i      (col_q),
    .pix_y_i      (row_q),
    .hit_o        (marker_hit)
  );

  // Border strips: top, left, and the bottom band h-B <= y < h.
  logic border_hit;
  assign border_hit = (XW'(row_q) < XW'(BORDER_THICKNESS))
                   || (XW'(col_q) < XW'(BORDER_THICKNESS))
                   || ((XW'(row_q) + XW'(BORDER_THICKNESS) >= XW'(eff_h))
                       && (XW'(row_q) < XW'(eff_h)));

  // output register
  logic [PIXEL_WIDTH-1:0] pixel_q;
  logic                   sof_q, eol_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pix_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      pixel_q <= (marker_hit || border_hit) ? OVERLAY_COLOUR : '0;
      sof_q   <= (col_q == '0) && (row_q == '0);
      eol_q   <= last_col;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pixel_o          = pixel_q;
  assign start_of_frame_o = sof_q;
  assign end_of_line_o    = eol_q;

endmodule

// ===== sim/video_marker_overlay_generator_top_test.sv =====
// Self-checking testbench for the video marker overlay generator top level.
`timescale 1ns / 1ps

module video_marker_overlay_generator_top_test;
  import vmog_pkg::*;

  localparam int unsigned MARKERS   = MARKER_COUNT_DEF;
  localparam int unsigned BORDER    = BORDER_THICKNESS_DEF;
  localparam int unsigned COORD_TOP = (1 << COORD_BITS_DEF) - 1;
  localparam int unsigned PHASES    = 12;
  localparam int unsigned LONG_PHASE = 9;
  localparam int unsigned HOLD_CYCLES = 100;

  // Tracks the raster position, the marker positions and the registers, and
  // keeps the pixels that the block still owes in order of acceptance.
  class overlay_pixel_tracker;
    typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   sof;
      logic                   eol;
    } pixel_word_t;

    logic [DIM_WIDTH-1:0]  width_reg;
    logic [DIM_WIDTH-1:0]  height_reg;
    logic [HALF_WIDTH-1:0] half_reg;
    int unsigned           column;
    int unsigned           row;
    int                    marker_col[MARKERS];
    int                    marker_row[MARKERS];
    pixel_word_t           pixels_due[$];
    int                    mismatches;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      half_reg   = HALF_SIZE_RST;
      column     = 0;
      row        = 0;
      mismatches = 0;
      foreach (marker_col[k]) begin
        marker_col[k] = 0;
        marker_row[k] = 0;
      end
    endfunction

    function void set_register(cfg_reg_e r, logic [CFG_DATA_WIDTH-1:0] v);
      case (r)
        REG_FRAME_WIDTH:  width_reg  = v[DIM_WIDTH-1:0];
        REG_FRAME_HEIGHT: height_reg = v[DIM_WIDTH-1:0];
        REG_HALF_SIZE:    half_reg   = v[HALF_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Zero or anything past the maximum behaves as the maximum.
    function int unsigned active_dim(logic [DIM_WIDTH-1:0] v);
      return (v == '0 || v > DIM_MAX) ? int'(DIM_MAX) : int'(v);
    endfunction

    function bit under_marker(int x, int y);
      int s;
      s = half_reg;
      for (int k = 0; k < MARKERS; k++) begin
        if (x >= marker_col[k] - s && x <= marker_col[k] + s &&
            y >= marker_row[k] - s && y <= marker_row[k] + s) begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void take_word(action_e act, logic [IDX_WIDTH-1:0] idx,
                            logic [FIELD_WIDTH-1:0] mx, logic [FIELD_WIDTH-1:0] my);
      int unsigned w, h, x, y;
      bit          last_col, last_row, marked;
      int          hb;
      pixel_word_t due;
      if (act == ACT_LOAD) begin
        // Loads past the end of the marker list are dropped
        if (idx < MARKERS) begin
          marker_col[idx] = int'(mx) & COORD_TOP;
          marker_row[idx] = int'(my) & COORD_TOP;
        end
        return;
      end
      w = active_dim(width_reg);
      h = active_dim(height_reg);
      x = column & COORD_TOP;
      y = row & COORD_TOP;
      // A counter left past the end by a register change counts as the last spot
      last_col = (x >= w - 1) || (x == COORD_TOP);
      last_row = (y >= h - 1) || (y == COORD_TOP);
      hb = int'(h) - int'(BORDER);
      marked = under_marker(int'(x), int'(y)) || y < BORDER ||
               (int'(y) >= hb && y < h) || x < BORDER;
      due.pixel = marked ? OVERLAY_COLOUR : '0;
      due.sof   = (x == 0 && y == 0);
      due.eol   = last_col;
      pixels_due.push_back(due);
      if (last_col) begin
        column = 0;
        row    = last_row ? 0 : ((y + 1) & COORD_TOP);
      end else begin
        column = (x + 1) & COORD_TOP;
      end
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task match_pixel(logic [PIXEL_WIDTH-1:0] pixel, logic sof, logic eol);
      pixel_word_t due;
      if (pixels_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word pixel=%h sof=%b eol=%b", pixel, sof, eol));
        return;
      end
      due = pixels_due.pop_front();
      if (pixel !== due.pixel) begin
        flag_mismatch($sformatf("pixel got %h want %h", pixel, due.pixel));
      end
      if (sof !== due.sof) begin
        flag_mismatch($sformatf("start_of_frame got %b want %b", sof, due.sof));
      end
      if (eol !== due.eol) begin
        flag_mismatch($sformatf("end_of_line got %b want %b", eol, due.eol));
      end
    endtask
  endclass

  // Clock, reset and every block input start at known values
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]   cfg_index_i    = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata_i    = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic                       action_i       = 1'b0;
  logic [IDX_WIDTH-1:0]       marker_index_i = '0;
  logic [FIELD_WIDTH-1:0]     marker_x_i     = '0;
  logic [FIELD_WIDTH-1:0]     marker_y_i     = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic [PIXEL_WIDTH-1:0]     pixel_o;
  logic                       start_of_frame_o;
  logic                       end_of_line_o;

  overlay_pixel_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;

  always #5 clk_i = ~clk_i;

  video_marker_overlay_generator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .marker_index_i   (marker_index_i),
    .marker_x_i       (marker_x_i),
    .marker_y_i       (marker_y_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_o          (pixel_o),
    .start_of_frame_o (start_of_frame_o),
    .end_of_line_o    (end_of_line_o)
  );

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the block backs up and stalls its input while the sender keeps offering.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every pixel word the block hands over, using pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.match_pixel(pixel_o, start_of_frame_o, end_of_line_o);
    end
  end

  // Offer one word, with random idle cycles first; return once it is taken.
  task automatic send_word(action_e act, logic [IDX_WIDTH-1:0] idx,
                           logic [FIELD_WIDTH-1:0] mx, logic [FIELD_WIDTH-1:0] my);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    marker_index_i <= idx;
    marker_x_i     <= mx;
    marker_y_i     <= my;
    // Hold the payload until the block stops stalling
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_word(act, idx, mx, my);
  endtask

  // Drop valid and wait until every owed pixel is out; the extra cycles let a
  // trailing load retire before any register changes.
  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_WIDTH-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_register(r, v);
  endtask

  // Mostly small frames so lines and frames wrap often; sometimes any value or an edge case.
  function automatic logic [DIM_WIDTH-1:0] pick_dim(int unsigned small_top);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return DIM_WIDTH'($urandom_range(1, small_top));
    if (r < 90) return DIM_WIDTH'($urandom_range(0, 4095));
    case ($urandom_range(3))
      0:       return '0;
      1:       return DIM_WIDTH'(1);
      2:       return DIM_MAX;
      default: return '1;
    endcase
  endfunction

  initial begin : stimulus
    logic [DIM_WIDTH-1:0]  w_set, h_set;
    logic [HALF_WIDTH-1:0] half_set;
    int unsigned           words, load_pct, reach_x, reach_y;
    action_e               act;

    tracker = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 86;

    // Directed: reset registers and table, field extremes, dropped loads
    send_word(ACT_PIXEL, 5'd31, 11'h7ff, 11'h7ff);
    send_word(ACT_LOAD, 5'd0, 11'h7ff, 11'h7ff);
    send_word(ACT_LOAD, 5'd19, 11'd4, 11'd3);
    send_word(ACT_LOAD, 5'd20, 11'h555, 11'h2aa);
    send_word(ACT_LOAD, 5'd31, 11'h2aa, 11'h555);
    send_word(ACT_LOAD, 5'd10, 11'd0, 11'h7ff);
    for (int i = 0; i < 16; i++) begin
      send_word(ACT_PIXEL, IDX_WIDTH'($urandom), FIELD_WIDTH'($urandom),
                FIELD_WIDTH'($urandom));
    end
    drain_words();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      // Sender mostly busy first, then receiver mostly busy, then no gaps
      if (phase < 4) begin
        send_idle_pct = 11;
        recv_idle_pct = 86;
      end else if (phase < 8) begin
        send_idle_pct = 86;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      load_pct = 25;
      words    = $urandom_range(120, 170);
      if (phase == 0) begin
        // Smallest frame: every pixel starts a frame and ends a line
        w_set    = DIM_WIDTH'(1);
        h_set    = DIM_WIDTH'(1);
        half_set = '0;
      end else if (phase == LONG_PHASE) begin
        // Oversized and zero dimensions act as the maximum
        w_set    = '1;
        h_set    = '0;
        half_set = '1;
        load_pct = 4;
      end else begin
        w_set    = pick_dim(40);
        h_set    = pick_dim(24);
        half_set = ($urandom_range(9) == 0) ? HALF_WIDTH'($urandom_range(0, 255))
                                            : HALF_WIDTH'($urandom_range(0, 6));
      end
      write_reg(REG_FRAME_WIDTH, w_set);
      write_reg(REG_FRAME_HEIGHT, h_set);
      write_reg(REG_HALF_SIZE, {4'($urandom), half_set});

      reach_x = tracker.active_dim(w_set) + half_set;
      reach_y = tracker.active_dim(h_set) + half_set;
      if (reach_x > COORD_TOP) reach_x = COORD_TOP;
      if (reach_y > COORD_TOP) reach_y = COORD_TOP;

      if (phase == 2) hold_req = 1'b1;

      for (int unsigned i = 0; i < words; i++) begin
        act = ($urandom_range(99) < load_pct) ? ACT_LOAD : ACT_PIXEL;
        // Keep most markers near the frame so they show up, some anywhere
        send_word(act,
                  ($urandom_range(99) < 85) ? IDX_WIDTH'($urandom_range(0, MARKERS - 1))
                                            : IDX_WIDTH'($urandom_range(MARKERS, 31)),
                  ($urandom_range(9) < 7) ? FIELD_WIDTH'($urandom_range(0, reach_x))
                                          : FIELD_WIDTH'($urandom_range(0, COORD_TOP)),
                  ($urandom_range(9) < 7) ? FIELD_WIDTH'($urandom_range(0, reach_y))
                                          : FIELD_WIDTH'($urandom_range(0, COORD_TOP)));
      end
      drain_words();
    end

    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up if the block stops moving words
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vmog_pkg.sv
rtl/vmog_marker_match.sv
rtl/video_marker_overlay_generator_top.sv
sim/video_marker_overlay_generator_top_test.sv
